>>> rtl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising edge of clk while rst_n is high.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// An implication checked at every rising edge of clk while rst_n is high.
`define ASSERT_IMPL(label, cond, prop, msg) \
    `ASSERT_CLK(label, (cond) |-> (prop), msg)

`endif

>>> rtl/lcdfw_pkg.sv
package lcdfw_pkg;

    localparam int FRAME_BITS = 56;
    localparam int IDX_W = 6;
    localparam int GLYPH_BITS = 40;

    localparam logic [1:0] MODE_CMD = 2'd0;
    localparam logic [1:0] MODE_DATA = 2'd1;
    localparam logic [1:0] MODE_CHAR = 2'd2;
    localparam logic [1:0] MODE_CURSOR = 2'd3;

    localparam logic [7:0] CMD_SET_X = 8'h80;
    localparam logic [7:0] CMD_SET_Y = 8'h40;
    localparam logic [7:0] BLANK_COL = 8'h00;
    localparam logic [7:0] FONT_FIRST = 8'h20;
    localparam logic [3:0] COL_MAX = 4'd11;
    localparam logic [2:0] ROW_MAX = 3'd5;
    localparam logic [7:0] CHAR_WIDTH = 8'd7;

    localparam logic [IDX_W-1:0] LAST_ONE_BYTE = 6'd7;
    localparam logic [IDX_W-1:0] LAST_TWO_BYTES = 6'd15;
    localparam logic [IDX_W-1:0] LAST_CHAR = 6'd55;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] byte_value;
        logic [3:0] cursor_col;
        logic [2:0] cursor_row;
    } lcdfw_item_t;

    typedef struct packed {
        logic mosi_bit;
        logic dc_flag;
        logic byte_end;
        logic last;
    } lcdfw_result_t;

    typedef struct packed {
        logic [FRAME_BITS-1:0] bits;
        logic [IDX_W-1:0]      last_idx;
        logic                  dc_flag;
    } lcdfw_frame_t;

    function automatic logic [GLYPH_BITS-1:0] font_glyph(input logic [6:0] idx);
        logic [GLYPH_BITS-1:0] g;
        unique case (idx)
            7'd0:  g = 40'h0000000000;
            7'd1:  g = 40'h00005f0000;
            7'd2:  g = 40'h0007000700;
            7'd3:  g = 40'h147f147f14;
            7'd4:  g = 40'h242a7f2a12;
            7'd5:  g = 40'h2313086462;
            7'd6:  g = 40'h3649552250;
            7'd7:  g = 40'h0005030000;
            7'd8:  g = 40'h001c224100;
            7'd9:  g = 40'h0041221c00;
            7'd10: g = 40'h14083e0814;
            7'd11: g = 40'h08083e0808;
            7'd12: g = 40'h0050300000;
            7'd13: g = 40'h0808080808;
            7'd14: g = 40'h0060600000;
            7'd15: g = 40'h2010080402;
            7'd16: g = 40'h3e5149453e;
            7'd17: g = 40'h00427f4000;
            7'd18: g = 40'h4261514946;
            7'd19: g = 40'h2141454b31;
            7'd20: g = 40'h1814127f10;
            7'd21: g = 40'h2745454539;
            7'd22: g = 40'h3c4a494930;
            7'd23: g = 40'h0171090503;
            7'd24: g = 40'h3649494936;
            7'd25: g = 40'h064949291e;
            7'd26: g = 40'h0036360000;
            7'd27: g = 40'h0056360000;
            7'd28: g = 40'h0814224100;
            7'd29: g = 40'h1414141414;
            7'd30: g = 40'h0041221408;
            7'd31: g = 40'h0201510906;
            7'd32: g = 40'h324979413e;
            7'd33: g = 40'h7e1111117e;
            7'd34: g = 40'h7f49494936;
            7'd35: g = 40'h3e41414122;
            7'd36: g = 40'h7f4141221c;
            7'd37: g = 40'h7f49494941;
            7'd38: g = 40'h7f09090901;
            7'd39: g = 40'h3e4149497a;
            7'd40: g = 40'h7f0808087f;
            7'd41: g = 40'h00417f4100;
            7'd42: g = 40'h2040413f01;
            7'd43: g = 40'h7f08142241;
            7'd44: g = 40'h7f40404040;
            7'd45: g = 40'h7f020c027f;
            7'd46: g = 40'h7f0408107f;
            7'd47: g = 40'h3e4141413e;
            7'd48: g = 40'h7f09090906;
            7'd49: g = 40'h3e4151215e;
            7'd50: g = 40'h7f09192946;
            7'd51: g = 40'h4649494931;
            7'd52: g = 40'h01017f0101;
            7'd53: g = 40'h3f4040403f;
            7'd54: g = 40'h1f2040201f;
            7'd55: g = 40'h3f4038403f;
            7'd56: g = 40'h6314081463;
            7'd57: g = 40'h0708700807;
            7'd58: g = 40'h6151494543;
            7'd59: g = 40'h007f414100;
            7'd60: g = 40'h0204081020;
            7'd61: g = 40'h0041417f00;
            7'd62: g = 40'h0402010204;
            7'd63: g = 40'h4040404040;
            7'd64: g = 40'h0001020400;
            7'd65: g = 40'h2054545478;
            7'd66: g = 40'h7f48444438;
            7'd67: g = 40'h3844444420;
            7'd68: g = 40'h384444487f;
            7'd69: g = 40'h3854545418;
            7'd70: g = 40'h087e090102;
            7'd71: g = 40'h0c5252523e;
            7'd72: g = 40'h7f08040478;
            7'd73: g = 40'h00447d4000;
            7'd74: g = 40'h2040443d00;
            7'd75: g = 40'h7f10284400;
            7'd76: g = 40'h00417f4000;
            7'd77: g = 40'h7c04180478;
            7'd78: g = 40'h7c08040478;
            7'd79: g = 40'h3844444438;
            7'd80: g = 40'h7c14141408;
            7'd81: g = 40'h081414187c;
            7'd82: g = 40'h7c08040408;
            7'd83: g = 40'h4854545420;
            7'd84: g = 40'h043f444020;
            7'd85: g = 40'h3c4040207c;
            7'd86: g = 40'h1c2040201c;
            7'd87: g = 40'h3c4030403c;
            7'd88: g = 40'h4428102844;
            7'd89: g = 40'h0c5050503c;
            7'd90: g = 40'h4464544c44;
            7'd91: g = 40'h0008364100;
            7'd92: g = 40'h00007f0000;
            7'd93: g = 40'h0041360800;
            7'd94: g = 40'h1008081008;
            7'd95: g = 40'h1f247c241f;
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

>>> rtl/lcdfw_front.sv
module lcdfw_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  lcdfw_pkg::lcdfw_item_t  item,
    output logic                 q_push,
    input  logic                 q_full,
    output lcdfw_pkg::lcdfw_frame_t q_frame
);
    import lcdfw_pkg::*;

    logic         frame_valid_reg;
    logic         frame_valid_next;
    lcdfw_frame_t frame_reg;
    lcdfw_frame_t frame_next;
    logic         accept;
    logic         keep;
    logic         known;
    logic [7:0]   code_off;
    logic [7:0]   x_cmd;
    logic [7:0]   y_cmd;

    assign full = frame_valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = frame_valid_reg && !q_full;
    assign q_frame = frame_reg;

    assign code_off = item.byte_value - FONT_FIRST;
    assign known = (item.byte_value >= FONT_FIRST) && !item.byte_value[7];
    assign x_cmd = CMD_SET_X | (8'(item.cursor_col) * CHAR_WIDTH);
    assign y_cmd = CMD_SET_Y | 8'(item.cursor_row);

    always_comb
    begin
        keep = 1'b1;
        frame_next = '0;
        unique case (item.mode)
            MODE_CMD:
            begin
                frame_next.bits = {item.byte_value, 48'd0};
                frame_next.last_idx = LAST_ONE_BYTE;
                frame_next.dc_flag = 1'b0;
            end
            MODE_DATA:
            begin
                frame_next.bits = {item.byte_value, 48'd0};
                frame_next.last_idx = LAST_ONE_BYTE;
                frame_next.dc_flag = 1'b1;
            end
            MODE_CHAR:
            begin
                frame_next.bits = {BLANK_COL,
                    known ? font_glyph(code_off[6:0]) : {GLYPH_BITS{1'b0}}, BLANK_COL};
                frame_next.last_idx = LAST_CHAR;
                frame_next.dc_flag = 1'b1;
            end
            MODE_CURSOR:
            begin
                keep = (item.cursor_col <= COL_MAX) && (item.cursor_row <= ROW_MAX);
                frame_next.bits = {x_cmd, y_cmd, 40'd0};
                frame_next.last_idx = LAST_TWO_BYTES;
                frame_next.dc_flag = 1'b0;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        frame_valid_next = frame_valid_reg;
        if (q_push)
        begin
            frame_valid_next = 1'b0;
        end
        if (accept && keep)
        begin
            frame_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg <= 1'b0;
        end
        else
        begin
            frame_valid_reg <= frame_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            frame_reg <= frame_next;
        end
    end

endmodule

>>> rtl/lcdfw_queue.sv
module lcdfw_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  lcdfw_pkg::lcdfw_frame_t wr_frame,
    input  logic                   pop,
    output logic                   empty,
    output lcdfw_pkg::lcdfw_frame_t rd_frame
);
    import lcdfw_pkg::*;

    lcdfw_frame_t slot_reg [2];
    logic         wr_ptr_reg;
    logic         wr_ptr_next;
    logic         rd_ptr_reg;
    logic         rd_ptr_next;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    logic         do_push;
    logic         do_pop;

    assign full = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign rd_frame = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_frame;
        end
    end

endmodule

>>> rtl/lcdfw_back.sv
module lcdfw_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    output logic                   q_pop,
    input  lcdfw_pkg::lcdfw_frame_t q_frame,
    output logic                   out_valid,
    input  logic                   out_take,
    output lcdfw_pkg::lcdfw_result_t out_word
);
    import lcdfw_pkg::*;

    logic                  busy_reg;
    logic                  busy_next;
    logic [FRAME_BITS-1:0] shift_reg;
    logic [FRAME_BITS-1:0] shift_next;
    logic [IDX_W-1:0]      cnt_reg;
    logic [IDX_W-1:0]      cnt_next;
    logic [IDX_W-1:0]      last_idx_reg;
    logic [IDX_W-1:0]      last_idx_next;
    logic                  dc_reg;
    logic                  dc_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    lcdfw_result_t         out_reg;
    lcdfw_result_t         out_next;
    logic                  emit;
    logic                  is_last;
    logic                  load;

    assign emit = busy_reg && (!out_valid_reg || out_take);
    assign is_last = cnt_reg == last_idx_reg;
    assign load = !q_empty && (!busy_reg || (emit && is_last));
    assign q_pop = load;
    assign out_valid = out_valid_reg;
    assign out_word = out_reg;

    always_comb
    begin
        busy_next = busy_reg;
        shift_next = shift_reg;
        cnt_next = cnt_reg;
        last_idx_next = last_idx_reg;
        dc_next = dc_reg;
        out_valid_next = out_valid_reg;
        out_next = out_reg;
        if (out_take)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_next.mosi_bit = shift_reg[FRAME_BITS-1];
            out_next.dc_flag = dc_reg;
            out_next.byte_end = cnt_reg[2:0] == 3'd7;
            out_next.last = is_last;
            shift_next = {shift_reg[FRAME_BITS-2:0], 1'b0};
            cnt_next = cnt_reg + IDX_W'(1);
            if (is_last)
            begin
                busy_next = 1'b0;
            end
        end
        if (load)
        begin
            busy_next = 1'b1;
            shift_next = q_frame.bits;
            cnt_next = '0;
            last_idx_next = q_frame.last_idx;
            dc_next = q_frame.dc_flag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        cnt_reg <= cnt_next;
        last_idx_reg <= last_idx_next;
        dc_reg <= dc_next;
        out_reg <= out_next;
    end

endmodule

>>> rtl/lcd_font_char_spi_writer_top.sv
// Channel  | Handshake        | Word
// ---------+------------------+-------------------------------------------
// request  | push / full      | item: mode, byte_value, cursor_col/row
// bit      | pop / empty      | result: mosi_bit, dc_flag, byte_end, last
//
// The serializer sends one bit per cycle while every bit is popped: a command or data
// request sends 8 bits, a character 56, a cursor 16, with no gap between queued requests.
// An out-of-range cursor request is accepted and dropped without output.
// Up to three requests are held ahead of the serializer, and a stalled bit holds the line.
// Reset clears the queues and the serializer; there is no other state.
module lcd_font_char_spi_writer_top (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  lcdfw_pkg::lcdfw_item_t   item,
    output logic                    empty,
    input  logic                    pop,
    output lcdfw_pkg::lcdfw_result_t result
);
    import lcdfw_pkg::*;

    logic         f_push;
    logic         f_full;
    lcdfw_frame_t f_frame;
    logic         b_pop;
    logic         b_empty;
    lcdfw_frame_t b_frame;
    logic         out_valid;

    lcdfw_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .q_push  (f_push),
        .q_full  (f_full),
        .q_frame (f_frame)
    );

    lcdfw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (f_push),
        .full     (f_full),
        .wr_frame (f_frame),
        .pop      (b_pop),
        .empty    (b_empty),
        .rd_frame (b_frame)
    );

    lcdfw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (b_empty),
        .q_pop     (b_pop),
        .q_frame   (b_frame),
        .out_valid (out_valid),
        .out_take  (pop && out_valid),
        .out_word  (result)
    );

    assign empty = !out_valid;

endmodule

>>> rtl/lcdfw_checker.sv
`include "assert_macros.svh"

module lcdfw_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    empty,
    input logic                    pop,
    input lcdfw_pkg::lcdfw_result_t result
);
    import lcdfw_pkg::*;

    logic [2:0] bit_pos_reg;
    logic [2:0] bit_pos_next;
    logic       dc_reg;
    logic       dc_next;
    logic       taken;

    assign taken = pop && !empty;

    always_comb
    begin
        bit_pos_next = bit_pos_reg;
        dc_next = dc_reg;
        if (taken)
        begin
            bit_pos_next = bit_pos_reg + 3'd1;
            dc_next = result.dc_flag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_pos_reg <= 3'd0;
            dc_reg <= 1'b0;
        end
        else
        begin
            bit_pos_reg <= bit_pos_next;
            dc_reg <= dc_next;
        end
    end

    `ASSERT_CLK(a_stall_holds, (!empty && !pop) |=> (!empty && $stable(result)), "stalled word changed")
    `ASSERT_IMPL(a_last_ends_byte, !empty && result.last, result.byte_end, "last bit not at a byte end")
    `ASSERT_IMPL(a_byte_end_eighth, !empty, result.byte_end == (bit_pos_reg == 3'd7), "byte end misplaced")
    `ASSERT_IMPL(a_dc_steady, !empty && bit_pos_reg != 3'd0, result.dc_flag == dc_reg, "flag changed inside a byte")

endmodule

bind lcd_font_char_spi_writer_top lcdfw_checker u_lcdfw_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

    import lcdfw_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 80;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          push = 1'b0;
    logic          full;
    lcdfw_item_t   item = '0;
    logic          empty;
    logic          pop = 1'b0;
    lcdfw_result_t result;

    lcdfw_result_t bit_q[$];
    lcdfw_result_t want;
    int            errors = 0;
    int            cycle_count = 0;
    bit            no_gaps = 1'b0;
    bit            hold_req = 1'b0;
    int            hold_cnt = 0;
    int            pop_idle_cnt = 0;

    logic [39:0] glyph_rom [0:95] = '{
        40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
        40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
        40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
        40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
        40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
        40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
        40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
        40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
        40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
        40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
        40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
        40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
        40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
        40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
        40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
        40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
        40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
        40'h00007f0000, 40'h0041360800, 40'h1008081008, 40'h1f247c241f
    };

    lcd_font_char_spi_writer_top DUT (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .item(item),
        .empty(empty),
        .pop(pop),
        .result(result)
    );

    always #10 clk = ~clk;

    function automatic void queue_byte(input logic [7:0] value, input logic dc,
                                       input logic final_byte);
        lcdfw_result_t r;
        for (int b = 7; b >= 0; b--)
        begin
            r.mosi_bit = value[b];
            r.dc_flag = dc;
            r.byte_end = (b == 0);
            r.last = final_byte && (b == 0);
            bit_q.push_back(r);
        end
    endfunction

    function automatic void predict_bits(input lcdfw_item_t w);
        logic [39:0] cols;
        logic [7:0]  code_off;
        case (w.mode)
            MODE_CMD: queue_byte(w.byte_value, 1'b0, 1'b1);
            MODE_DATA: queue_byte(w.byte_value, 1'b1, 1'b1);
            MODE_CHAR:
            begin
                code_off = w.byte_value - 8'h20;
                if (w.byte_value >= 8'h20 && w.byte_value <= 8'h7f)
                    cols = glyph_rom[code_off[6:0]];
                else
                    cols = '0;
                queue_byte(8'h00, 1'b1, 1'b0);
                for (int i = 4; i >= 0; i--)
                    queue_byte(cols[i*8 +: 8], 1'b1, 1'b0);
                queue_byte(8'h00, 1'b1, 1'b1);
            end
            default:
            begin
                if (w.cursor_col <= 4'd11 && w.cursor_row <= 3'd5)
                begin
                    queue_byte(8'h80 | (8'(w.cursor_col) * 8'd7), 1'b0, 1'b0);
                    queue_byte(8'h40 | 8'(w.cursor_row), 1'b0, 1'b1);
                end
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic exp_v,
                                        input logic act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0b, got %0b", name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                predict_bits(item);
            if (pop && !empty)
            begin
                if (bit_q.size() == 0)
                begin
                    $error("result word arrived with none expected");
                    errors++;
                end
                else
                begin
                    want = bit_q.pop_front();
                    check_field("mosi_bit", want.mosi_bit, result.mosi_bit);
                    check_field("dc_flag", want.dc_flag, result.dc_flag);
                    check_field("byte_end", want.byte_end, result.byte_end);
                    check_field("last", want.last, result.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_cnt = HOLD_CYCLES;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            pop <= 1'b0;
        end
        else if (no_gaps)
            pop <= 1'b1;
        else if (pop_idle_cnt > 0)
        begin
            pop_idle_cnt--;
            pop <= 1'b0;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            pop_idle_cnt = $urandom_range(1, 4) - 1;
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_word(input lcdfw_item_t w);
        item <= w;
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (!no_gaps && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    function automatic lcdfw_item_t make_item(input logic [1:0] m, input logic [7:0] v,
                                             input logic [3:0] c, input logic [2:0] r);
        lcdfw_item_t w;
        w.mode = m;
        w.byte_value = v;
        w.cursor_col = c;
        w.cursor_row = r;
        return w;
    endfunction

    function automatic lcdfw_item_t rand_item();
        lcdfw_item_t w;
        w.mode = 2'($urandom_range(0, 3));
        w.byte_value = 8'($urandom);
        w.cursor_col = 4'($urandom);
        w.cursor_row = 3'($urandom);
        if (w.mode == MODE_CHAR && $urandom_range(0, 9) != 0)
            w.byte_value = 8'($urandom_range(8'h20, 8'h7f));
        if (w.mode == MODE_CURSOR && $urandom_range(0, 4) != 0)
        begin
            w.cursor_col = 4'($urandom_range(0, 11));
            w.cursor_row = 3'($urandom_range(0, 5));
        end
        return w;
    endfunction

    task automatic test_command_data();
        send_word(make_item(MODE_CMD, 8'h00, 4'hf, 3'h7));
        send_word(make_item(MODE_CMD, 8'hff, 4'h0, 3'h0));
        send_word(make_item(MODE_DATA, 8'h00, 4'h0, 3'h0));
        send_word(make_item(MODE_DATA, 8'hff, 4'hf, 3'h7));
        send_word(make_item(MODE_DATA, 8'ha5, 4'h5, 3'h2));
        send_word(make_item(MODE_CMD, 8'h5a, 4'ha, 3'h5));
    endtask

    task automatic test_characters();
        send_word(make_item(MODE_CHAR, 8'h20, 4'h0, 3'h0));
        send_word(make_item(MODE_CHAR, 8'h7f, 4'hf, 3'h7));
        send_word(make_item(MODE_CHAR, 8'h1f, 4'h0, 3'h0));
        send_word(make_item(MODE_CHAR, 8'h00, 4'h0, 3'h0));
        send_word(make_item(MODE_CHAR, 8'h80, 4'h3, 3'h1));
        send_word(make_item(MODE_CHAR, 8'hff, 4'h0, 3'h0));
        send_word(make_item(MODE_CHAR, 8'h41, 4'h0, 3'h0));
    endtask

    task automatic test_cursor();
        send_word(make_item(MODE_CURSOR, 8'hff, 4'd0, 3'd0));
        send_word(make_item(MODE_CURSOR, 8'h00, 4'd11, 3'd5));
        send_word(make_item(MODE_CURSOR, 8'h00, 4'd12, 3'd0));
        send_word(make_item(MODE_CURSOR, 8'h3c, 4'd0, 3'd6));
        send_word(make_item(MODE_CURSOR, 8'hc3, 4'd15, 3'd7));
        send_word(make_item(MODE_CURSOR, 8'h81, 4'd5, 3'd3));
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++)
            send_word(make_item(MODE_CHAR, 8'($urandom_range(8'h20, 8'h7f)),
                                4'($urandom), 3'($urandom)));
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_word(rand_item());
    endtask

    task automatic test_no_gaps(input int count);
        no_gaps = 1'b1;
        test_random(count);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_command_data();
        test_characters();
        test_cursor();
        test_backpressure();
        test_random(250);
        test_no_gaps(30);
        push <= 1'b0;
        while (bit_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
